[src/lmcfd_pkg.sv]
// types and constants for the led matrix chain frame driver
// no dependencies; imported by the top level
package lmcfd_pkg;

    // command codes carried in the kind field
    localparam logic [2:0] KIND_LED       = 3'd0;
    localparam logic [2:0] KIND_ROW       = 3'd1;
    localparam logic [2:0] KIND_COLUMN    = 3'd2;
    localparam logic [2:0] KIND_CLEAR     = 3'd3;
    localparam logic [2:0] KIND_INTENSITY = 3'd4;
    localparam logic [2:0] KIND_SCANLIMIT = 3'd5;
    localparam logic [2:0] KIND_RAW       = 3'd6;

    // controller register addresses
    localparam logic [3:0] ADDR_INTENSITY = 4'd10;
    localparam logic [3:0] ADDR_SCANLIMIT = 4'd11;

    // range limits for intensity and scan limit data
    localparam logic [7:0] INTENSITY_LIMIT = 8'd16;
    localparam logic [7:0] SCANLIMIT_LIMIT = 8'd8;

    // bit for column 0 within a row byte
    localparam logic [7:0] COL0_MASK = 8'h80;

    localparam logic [2:0] ROW_LAST        = 3'd7;
    localparam logic [3:0] CHAIN_LEN_RESET = 4'd4;

    // one command word
    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] device;
        logic [2:0] row;
        logic [2:0] column;
        logic       led_on;
        logic [7:0] data;
        logic [3:0] opcode;
    } t_in_word;

    // one serial word for the chain
    typedef struct packed {
        logic [15:0] word;
        logic        frame_end;
        logic        last;
    } t_out_word;

endpackage

[src/led_matrix_chain_frame_driver_top.sv]
// top level of the led matrix chain frame driver
// depends on lmcfd_pkg and lmcfd_ram
//
// Usage: one command word enters on the input channel (i_in_valid / o_in_stall)
// and the block answers with zero or more 16-bit chain words on the output
// channel (o_out_valid / i_out_stall). Words come out highest chain position
// first; frame_end marks the word where chip select latches, last marks the
// final word of the command. The chain length is written through i_cfg_we /
// i_cfg_data; the user must write it only while the block is idle, which the block itself does not enforce.
// Timing: the block takes one command at a time and holds o_in_stall high
// until its last word is in the output register. A frame is one word per
// chain position, one word per cycle while the output is not stalled (a
// single output register), after the framebuffer read and modify states on
// led and column commands. Column and clear commands give eight frames,
// others one frame; ignored commands are dropped in the cycle they are taken.
// Reset: chain length returns to 4 and the framebuffer reads as all zero at
// once (per row valid flags), so there is no clearing pass.
// A stalled output word holds; the sequencer waits while the output register
// is full and stalled.
module led_matrix_chain_frame_driver_top
    import lmcfd_pkg::*;
#(
    parameter int MAX_DEVICES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_we,
    input  logic [3:0] i_cfg_data
);

    localparam int DEPTH = MAX_DEVICES * 8;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAX_DEVICES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_MODIFY = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]       r_state;
    logic [3:0]       r_chain_len;
    t_in_word         r_item;
    logic [2:0]       r_row;
    logic [LW-1:0]    r_pos;
    logic [3:0]       r_op;
    logic [7:0]       r_value;
    logic [DEPTH-1:0] r_fb_valid;
    logic             r_out_valid;
    t_out_word        r_out;

    logic [LW-1:0] act_len;
    logic          in_accept;
    logic          cmd_ok;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] cur_addr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic [7:0]    old_byte;
    logic [7:0]    led_mask;
    logic          led_bit;
    logic [7:0]    new_byte;
    logic          out_free;
    logic          multi_row;
    logic          last_frame;

    // chain length in use, saturated at the framebuffer size
    always_comb begin
        if (int'(r_chain_len) > MAX_DEVICES) begin
            act_len = LW'(MAX_DEVICES);
        end else begin
            act_len = LW'(r_chain_len);
        end
    end

    // command filter
    always_comb begin
        cmd_ok = int'(i_in_word.device) < int'(act_len);
        case (i_in_word.kind)
            KIND_INTENSITY: cmd_ok = cmd_ok && (i_in_word.data < INTENSITY_LIMIT);
            KIND_SCANLIMIT: cmd_ok = cmd_ok && (i_in_word.data < SCANLIMIT_LIMIT);
            KIND_LED, KIND_ROW, KIND_COLUMN, KIND_CLEAR, KIND_RAW: cmd_ok = cmd_ok;
            default: cmd_ok = 1'b0;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && (r_state == ST_IDLE);
    assign in_addr    = AW'({i_in_word.device, i_in_word.row});
    assign cur_addr   = AW'({r_item.device, r_row});
    assign out_free   = !r_out_valid || !i_out_stall;

    // read modify write of one row byte
    assign old_byte = r_fb_valid[cur_addr] ? ram_rdata : 8'h00;
    assign led_mask = COL0_MASK >> r_item.column;
    assign led_bit  = (r_item.kind == KIND_LED) ? r_item.led_on
                                                : r_item.data[ROW_LAST - r_row];
    assign new_byte = led_bit ? (old_byte | led_mask) : (old_byte & ~led_mask);

    // framebuffer write port: row command at accept, led and column update in modify
    always_comb begin
        if (r_state == ST_MODIFY) begin
            ram_we    = 1'b1;
            ram_waddr = cur_addr;
            ram_wdata = new_byte;
        end else begin
            ram_we    = in_accept && cmd_ok && (i_in_word.kind == KIND_ROW);
            ram_waddr = in_addr;
            ram_wdata = i_in_word.data;
        end
    end

    lmcfd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_fb (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (cur_addr),
        .o_rdata (ram_rdata)
    );

    assign multi_row  = (r_item.kind == KIND_COLUMN) || (r_item.kind == KIND_CLEAR);
    assign last_frame = !multi_row || (r_row == ROW_LAST);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_len <= CHAIN_LEN_RESET;
        end else if (i_cfg_we) begin
            r_chain_len <= i_cfg_data;
        end
    end

    // framebuffer row valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_valid <= '0;
        end else if (in_accept && cmd_ok && (i_in_word.kind == KIND_CLEAR)) begin
            for (int r = 0; r < 8; r++) begin
                r_fb_valid[AW'({i_in_word.device, 3'(r)})] <= 1'b0;
            end
        end else if (ram_we) begin
            r_fb_valid[ram_waddr] <= 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_accept && cmd_ok) begin
                        r_item <= i_in_word;
                        r_pos  <= act_len - LW'(1);
                        case (i_in_word.kind)
                            KIND_LED: begin
                                r_row   <= i_in_word.row;
                                r_state <= ST_READ;
                            end
                            KIND_COLUMN: begin
                                r_row   <= 3'd0;
                                r_state <= ST_READ;
                            end
                            KIND_ROW: begin
                                r_row   <= i_in_word.row;
                                r_op    <= {1'b0, i_in_word.row} + 4'd1;
                                r_value <= i_in_word.data;
                                r_state <= ST_EMIT;
                            end
                            KIND_CLEAR: begin
                                r_row   <= 3'd0;
                                r_op    <= 4'd1;
                                r_value <= 8'h00;
                                r_state <= ST_EMIT;
                            end
                            KIND_INTENSITY: begin
                                r_row   <= 3'd0;
                                r_op    <= ADDR_INTENSITY;
                                r_value <= i_in_word.data;
                                r_state <= ST_EMIT;
                            end
                            KIND_SCANLIMIT: begin
                                r_row   <= 3'd0;
                                r_op    <= ADDR_SCANLIMIT;
                                r_value <= i_in_word.data;
                                r_state <= ST_EMIT;
                            end
                            default: begin
                                r_row   <= 3'd0;
                                r_op    <= i_in_word.opcode;
                                r_value <= i_in_word.data;
                                r_state <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    r_state <= ST_MODIFY;
                end
                ST_MODIFY: begin
                    r_op    <= {1'b0, r_row} + 4'd1;
                    r_value <= new_byte;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        if (r_pos == '0) begin
                            r_pos <= act_len - LW'(1);
                            if (last_frame) begin
                                r_state <= ST_IDLE;
                            end else begin
                                r_row <= r_row + 3'd1;
                                if (r_item.kind == KIND_CLEAR) begin
                                    r_op    <= {1'b0, r_row} + 4'd2;
                                    r_value <= 8'h00;
                                end else begin
                                    r_state <= ST_READ;
                                end
                            end
                        end else begin
                            r_pos <= r_pos - LW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && out_free) begin
            if (int'(r_pos) == int'(r_item.device)) begin
                r_out.word <= {4'h0, r_op, r_value};
            end else begin
                r_out.word <= 16'h0000;
            end
            r_out.frame_end <= (r_pos == '0);
            r_out.last      <= (r_pos == '0) && last_frame;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

[src/lmcfd_ram.sv]
// generic single write port ram with registered read
// no dependencies; holds the framebuffer rows
module lmcfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
